### design/newton_reciprocal_macros.svh
// Assertion macros for the newton_reciprocal checker.
`ifndef NEWTON_RECIPROCAL_MACROS_SVH
`define NEWTON_RECIPROCAL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/nr_pkg.sv
// Shared constants, types and width helpers for the Newton reciprocal block.
package nr_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 28;
  localparam int ITER_W = 7;
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(100);
  // operand b is consumed this many bits per multiplier cycle
  localparam int DIGIT_BITS = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP1,
    ST_STEP2,
    ST_FINISH
  } nr_state_t;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_ACC,
    MUL_SAT
  } mul_state_t;

  // divisor and initial_guess, padded to whole bytes
  function automatic int in_data_w(int word_bits);
    return ((2 * word_bits + 7) / 8) * 8;
  endfunction

  // reciprocal and iterations_used, padded to whole bytes
  function automatic int out_data_w(int word_bits);
    return ((word_bits + ITER_W + 7) / 8) * 8;
  endfunction

endpackage

### design/nr_mul.sv
// Digit-serial fixed-point multiplier: |a|*|b| with sign, floored and saturated.
module nr_mul #(
  parameter int WORD_BITS = nr_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = nr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [WORD_BITS-1:0]        a,
  input  logic [WORD_BITS-1:0]        b,
  input  logic                        neg,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] prod
);
  import nr_pkg::*;

  localparam int NDIG = (WORD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PADW = NDIG * DIGIT_BITS;
  localparam int ACCW = WORD_BITS + PADW;
  localparam int PPW  = WORD_BITS + DIGIT_BITS;
  localparam int DCW  = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int QW   = 2 * WORD_BITS - FRAC_BITS;
  localparam logic [DCW-1:0] LAST_DIG = DCW'(NDIG - 1);
  localparam logic [QW:0] POS_MAX = (QW+1)'({(WORD_BITS-1){1'b1}});
  localparam logic [QW:0] NEG_MAG_MAX = POS_MAX + (QW+1)'(1);
  localparam logic signed [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  mul_state_t state, state_next;

  logic [WORD_BITS-1:0] a_r;
  logic [PADW-1:0]      b_r;
  logic                 neg_r;
  logic [ACCW-1:0]      acc;
  logic [DCW-1:0]       dig;

  logic [DIGIT_BITS-1:0]       digit;
  logic [PPW-1:0]              pp;
  logic [ACCW-1:0]             addend;
  logic [QW:0]                 q;
  logic [QW:0]                 qr;
  logic                        rem;
  logic signed [WORD_BITS-1:0] sat;

  assign digit  = b_r[dig*DIGIT_BITS +: DIGIT_BITS];
  assign pp     = PPW'(a_r) * PPW'(digit);
  assign addend = ACCW'(pp) << (dig * DIGIT_BITS);

  // floor of the signed product: a negative result rounds its magnitude up
  assign q   = (QW+1)'(acc[2*WORD_BITS-1:FRAC_BITS]);
  assign rem = |acc[FRAC_BITS-1:0];
  assign qr  = q + (QW+1)'(rem);

  always_comb begin
    if (!neg_r) begin
      sat = (q > POS_MAX) ? SMAX : $signed(q[WORD_BITS-1:0]);
    end else begin
      sat = (qr > NEG_MAG_MAX) ? SMIN :
            $signed((~qr[WORD_BITS-1:0]) + WORD_BITS'(1));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      MUL_IDLE: if (start) state_next = MUL_ACC;
      MUL_ACC:  if (dig == LAST_DIG) state_next = MUL_SAT;
      MUL_SAT:  state_next = MUL_IDLE;
      default:  state_next = MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MUL_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MUL_SAT);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MUL_IDLE: begin
        if (start) begin
          a_r   <= a;
          b_r   <= PADW'(b);
          neg_r <= neg;
          acc   <= '0;
          dig   <= '0;
        end
      end
      MUL_ACC: begin
        acc <= acc + addend;
        dig <= dig + DCW'(1);
      end
      MUL_SAT: prod <= sat;
      default: ;
    endcase
  end

endmodule

### design/newton_reciprocal.sv
// Newton-Raphson reciprocal, fixed point, on one shared multiplier.
//
//  channel  | signals                        | item
//  ---------+--------------------------------+----------------------------------
//  s_axis   | tvalid tready tdata            | divisor, initial_guess
//  m_axis   | tvalid tready tdata tuser      | reciprocal, iterations_used; converged
//  cfg      | cfg_valid cfg_ready cfg_data   | max_iterations
//
// Each update runs two dependent multiplies on nr_mul; each multiply consumes b
// in NDIG digits (NDIG = ceil(WORD_BITS/32), 1 at 32 bits).
// One item is in flight; s_axis_tready is high only when idle.
// The result sits in an output register, so a new item is taken while it waits.
// rst is synchronous; max_iterations comes back as 100; cfg writes always accepted.
module newton_reciprocal #(
  parameter int WORD_BITS = nr_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = nr_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // divisor, initial_guess
  input  logic [nr_pkg::in_data_w(WORD_BITS)-1:0]    s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // reciprocal, iterations_used
  output logic [nr_pkg::out_data_w(WORD_BITS)-1:0]   m_axis_tdata,
  // converged
  output logic                                       m_axis_tuser,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [nr_pkg::ITER_W-1:0]                  cfg_data
);
  import nr_pkg::*;

  localparam int OUT_W = out_data_w(WORD_BITS);
  localparam logic signed [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam bit TWO_FITS = (FRAC_BITS + 2 < WORD_BITS);
  localparam logic signed [WORD_BITS-1:0] TWO =
    TWO_FITS ? (WORD_BITS'(1) << (FRAC_BITS + 1)) : SMAX;

  nr_state_t state, state_next;

  logic [ITER_W-1:0]           max_iter;
  logic [WORD_BITS-1:0]        x_r, x_next;
  logic signed [WORD_BITS-1:0] g, g_next;
  logic [ITER_W-1:0]           n, n_next;
  logic                        conv, conv_next;
  logic                        out_load;

  logic                        mul_start;
  logic [WORD_BITS-1:0]        mul_a;
  logic [WORD_BITS-1:0]        mul_b;
  logic                        mul_neg;
  logic                        mul_done;
  logic signed [WORD_BITS-1:0] mul_prod;

  logic [WORD_BITS-1:0]        in_div;
  logic signed [WORD_BITS-1:0] in_guess;
  logic [WORD_BITS-1:0]        in_mag;
  logic [WORD_BITS-1:0]        g_mag;
  logic [WORD_BITS-1:0]        prod_mag;
  logic signed [WORD_BITS+1:0] diff;
  logic signed [WORD_BITS-1:0] d;
  logic [WORD_BITS-1:0]        d_mag;
  logic [ITER_W-1:0]           n_inc;
  logic                        s_acc;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign in_div   = s_axis_tdata[WORD_BITS-1:0];
  assign in_guess = $signed(s_axis_tdata[2*WORD_BITS-1:WORD_BITS]);
  assign in_mag   = in_guess[WORD_BITS-1] ? (~in_guess) + WORD_BITS'(1) : in_guess;
  assign g_mag    = g[WORD_BITS-1] ? (~g) + WORD_BITS'(1) : g;
  assign prod_mag = mul_prod[WORD_BITS-1] ? (~mul_prod) + WORD_BITS'(1) : mul_prod;

  // d = 2 - t, saturated high (t is never far enough above 2 to underflow)
  assign diff  = (WORD_BITS+2)'(TWO) - {{2{mul_prod[WORD_BITS-1]}}, mul_prod};
  assign d     = (diff > (WORD_BITS+2)'(SMAX)) ? SMAX : diff[WORD_BITS-1:0];
  assign d_mag = d[WORD_BITS-1] ? (~d) + WORD_BITS'(1) : d;
  assign n_inc = n + ITER_W'(1);

  always_comb begin
    state_next = state;
    x_next     = x_r;
    g_next     = g;
    n_next     = n;
    conv_next  = conv;
    out_load   = 1'b0;
    mul_start  = 1'b0;
    mul_a      = x_r;
    mul_b      = g_mag;
    mul_neg    = g[WORD_BITS-1];
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          x_next    = in_div;
          g_next    = in_guess;
          n_next    = '0;
          conv_next = 1'b0;
          if (max_iter == '0) begin
            state_next = ST_FINISH;
          end else begin
            mul_start  = 1'b1;
            mul_a      = in_div;
            mul_b      = in_mag;
            mul_neg    = in_guess[WORD_BITS-1];
            state_next = ST_STEP1;
          end
        end
      end
      ST_STEP1: begin
        // t = x*g is ready; start g*(2 - t)
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = g_mag;
          mul_b      = d_mag;
          mul_neg    = g[WORD_BITS-1] ^ d[WORD_BITS-1];
          state_next = ST_STEP2;
        end
      end
      ST_STEP2: begin
        if (mul_done) begin
          if (mul_prod == g) begin
            conv_next  = 1'b1;
            state_next = ST_FINISH;
          end else begin
            g_next = mul_prod;
            n_next = n_inc;
            if (n_inc == max_iter) begin
              state_next = ST_FINISH;
            end else begin
              mul_start  = 1'b1;
              mul_a      = x_r;
              mul_b      = prod_mag;
              mul_neg    = mul_prod[WORD_BITS-1];
              state_next = ST_STEP1;
            end
          end
        end
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      max_iter      <= ITER_RESET;
      g             <= '0;
      n             <= '0;
      conv          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      g     <= g_next;
      n     <= n_next;
      conv  <= conv_next;
      if (cfg_valid) begin
        max_iter <= cfg_data;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_next;
    if (out_load) begin
      m_axis_tdata <= OUT_W'({n, g});
      m_axis_tuser <= conv;
    end
  end

  nr_mul #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .neg  (mul_neg),
    .done (mul_done),
    .prod (mul_prod)
  );

endmodule

### design/nr_chk.sv
// Port-level checker for newton_reciprocal, bound to the top level.
`include "newton_reciprocal_macros.svh"

module nr_chk #(
  parameter int WORD_BITS = nr_pkg::WORD_BITS_DEF
) (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     s_axis_tvalid,
  input logic                                     s_axis_tready,
  input logic                                     m_axis_tvalid,
  input logic                                     m_axis_tready,
  input logic [nr_pkg::out_data_w(WORD_BITS)-1:0] m_axis_tdata,
  input logic                                     m_axis_tuser,
  input logic                                     cfg_valid,
  input logic                                     cfg_ready
);
  import nr_pkg::*;

  logic                            s_acc;
  logic                            out_wait;
  logic [out_data_w(WORD_BITS):0]  out_word;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_wait = m_axis_tvalid && !m_axis_tready;
  assign out_word = {m_axis_tdata, m_axis_tuser};

  // a stalled result holds
  `NR_ASSERT_NEXT(a_hold, clk, rst, out_wait, m_axis_tvalid && $stable(out_word), "result moved")

  // one item at a time: busy right after an accept
  `NR_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_acc, !s_axis_tready, "input taken while busy")

  // no result can appear the cycle after an accept
  `NR_ASSERT_NEXT(a_no_instant_result, clk, rst, s_acc, !$rose(m_axis_tvalid), "result too early")

  // reset leaves the block idle with no result pending
  `NR_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !m_axis_tvalid && s_axis_tready, "not idle")

  // register writes are never stalled
  `NR_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind newton_reciprocal nr_chk #(.WORD_BITS(WORD_BITS)) u_nr_chk (.*);
